[hdl/tmsa_pkg.sv]
// shared types and constants of the trimmed mean sample aggregator
// no dependencies; imported by the controller, datapath and top level
package tmsa_pkg;

  localparam int SAMPLE_IN_W = 24;
  localparam int KIND_W      = 2;
  localparam int WLEN_W      = 5;
  localparam int CFG_DATA_W  = 5;
  localparam int CFG_INDEX_W = 1;
  localparam int LIMIT_W     = 9;
  localparam int FRAC_W      = 8;
  localparam int MEAN_INT_W  = 16;
  localparam int HUND_W      = 7;
  localparam int SEQ_W       = 8;
  localparam int CODE_W      = 3;
  localparam int MIN_WINDOW  = 5;
  localparam int HUND_SCALE  = 100;

  localparam logic [CFG_INDEX_W-1:0] REG_SENSOR_KIND   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 1'd1;

  localparam logic [KIND_W-1:0] KIND_LIGHT       = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PRESSURE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TEMPERATURE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_HUMIDITY    = 2'd3;

  localparam logic [WLEN_W-1:0] WINDOW_RESET = 5'd5;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic trim;
    logic div_step;
    logic load_out;
  } tmsa_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic window_last;
  } tmsa_status_t;

  // integer alarm threshold of each sensor kind
  function automatic logic [LIMIT_W-1:0] alarm_limit(input logic [KIND_W-1:0] kind);
    logic [LIMIT_W-1:0] lim;
    case (kind)
      KIND_PRESSURE:    lim = 9'd101;
      KIND_TEMPERATURE: lim = 9'd30;
      KIND_HUMIDITY:    lim = 9'd60;
      default:          lim = 9'd300;
    endcase
    return lim;
  endfunction

endpackage

[hdl/tmsa_datapath.sv]
// accumulators, config registers, serial divider and report registers
// depends on tmsa_pkg; driven by tmsa_controller commands
module tmsa_datapath #(
  parameter int MAX_WINDOW  = 30,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [tmsa_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tmsa_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [tmsa_pkg::SAMPLE_IN_W-1:0]  sample_value,
  input  tmsa_pkg::tmsa_cmd_t               cmd,
  output tmsa_pkg::tmsa_status_t            status,
  output logic [tmsa_pkg::SEQ_W-1:0]        report_seq,
  output logic [tmsa_pkg::CODE_W-1:0]       sensor_code,
  output logic [tmsa_pkg::MEAN_INT_W-1:0]   mean_integer,
  output logic [tmsa_pkg::HUND_W-1:0]       mean_hundredths,
  output logic                              alarm
);
  import tmsa_pkg::*;

  localparam int IN_W  = (SAMPLE_BITS < SAMPLE_IN_W) ? SAMPLE_BITS : SAMPLE_IN_W;
  localparam int SUM_W = IN_W + $clog2(MAX_WINDOW);
  localparam int IPW   = SUM_W - FRAC_W;
  localparam int CMP_W = (SUM_W > LIMIT_W + FRAC_W) ? SUM_W : LIMIT_W + FRAC_W;
  localparam int REM_W = WLEN_W + 1;
  localparam int PRD_W = FRAC_W + HUND_W;

  logic [KIND_W-1:0]   sensor_kind;
  logic [WLEN_W-1:0]   window_length;
  logic [WLEN_W-1:0]   fill_index;
  logic [SUM_W-1:0]    running_sum;
  logic [IN_W-1:0]     running_min;
  logic [IN_W-1:0]     running_max;
  logic [SEQ_W-1:0]    report_counter;
  logic [SUM_W-1:0]    dq;
  logic [REM_W-1:0]    rem;
  logic [WLEN_W-1:0]   divisor;

  logic [IN_W-1:0]     sample;
  logic [WLEN_W:0]     wl_ext;
  logic [WLEN_W:0]     eff_len;
  logic [WLEN_W:0]     fill_next;
  logic [SUM_W-1:0]    trimmed;
  logic [REM_W-1:0]    rem_sh;
  logic [REM_W-1:0]    rem_diff;
  logic                rem_ge;
  logic [IPW+MEAN_INT_W-1:0] ip_ext;
  logic                ip_sat;
  logic [PRD_W-1:0]    hund_prod;
  logic                over_limit;

  assign sample = sample_value[IN_W-1:0];

  // window length clamped to the supported range
  always_comb begin
    wl_ext = {1'b0, window_length};
    if (wl_ext < (WLEN_W+1)'(MIN_WINDOW)) begin
      eff_len = (WLEN_W+1)'(MIN_WINDOW);
    end else if (wl_ext > (WLEN_W+1)'(MAX_WINDOW)) begin
      eff_len = (WLEN_W+1)'(MAX_WINDOW);
    end else begin
      eff_len = wl_ext;
    end
  end

  assign fill_next          = {1'b0, fill_index} + (WLEN_W+1)'(1);
  assign status.window_last = (fill_next >= eff_len);

  assign trimmed = running_sum - SUM_W'(running_min) - SUM_W'(running_max);

  // restoring divide, one quotient bit per step
  assign rem_sh   = {rem[REM_W-2:0], dq[SUM_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, divisor});
  assign rem_diff = rem_sh - {1'b0, divisor};

  // report fields from the finished quotient
  assign ip_ext     = {MEAN_INT_W'(0), dq[SUM_W-1:FRAC_W]};
  assign ip_sat     = |ip_ext[IPW+MEAN_INT_W-1:MEAN_INT_W];
  assign hund_prod  = {HUND_W'(0), dq[FRAC_W-1:0]} * PRD_W'(HUND_SCALE);
  assign over_limit = CMP_W'(dq) > CMP_W'({alarm_limit(sensor_kind), FRAC_W'(0)});

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_kind    <= KIND_LIGHT;
      window_length  <= WINDOW_RESET;
      report_counter <= '0;
      fill_index     <= '0;
      running_sum    <= '0;
      running_min    <= '1;
      running_max    <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SENSOR_KIND: begin
            sensor_kind <= cfg_data[KIND_W-1:0];
            fill_index  <= '0;
            running_sum <= '0;
            running_min <= '1;
            running_max <= '0;
          end
          REG_WINDOW_LENGTH: begin
            window_length <= cfg_data[WLEN_W-1:0];
            fill_index    <= '0;
            running_sum   <= '0;
            running_min   <= '1;
            running_max   <= '0;
          end
          default: begin
          end
        endcase
      end else if (cmd.accept) begin
        running_sum <= running_sum + SUM_W'(sample);
        if (sample < running_min) begin
          running_min <= sample;
        end
        if (sample > running_max) begin
          running_max <= sample;
        end
        fill_index <= fill_index + WLEN_W'(1);
      end else if (cmd.trim) begin
        fill_index  <= '0;
        running_sum <= '0;
        running_min <= '1;
        running_max <= '0;
      end
      if (cmd.load_out) begin
        report_counter <= report_counter + SEQ_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.trim) begin
      dq      <= trimmed;
      rem     <= '0;
      divisor <= WLEN_W'(eff_len - (WLEN_W+1)'(2));
    end else if (cmd.div_step) begin
      rem <= rem_ge ? rem_diff : rem_sh;
      dq  <= {dq[SUM_W-2:0], rem_ge};
    end
    if (cmd.load_out) begin
      report_seq      <= report_counter;
      sensor_code     <= {1'b0, sensor_kind} + CODE_W'(1);
      mean_integer    <= ip_sat ? '1 : ip_ext[MEAN_INT_W-1:0];
      mean_hundredths <= ip_sat ? HUND_W'(99) : hund_prod[PRD_W-1:FRAC_W];
      alarm           <= over_limit;
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (rem < {1'b0, divisor}))
    else $error("divider remainder not below divisor");

  a_fill_in_window: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |-> ({1'b0, fill_index} < eff_len))
    else $error("sample accepted past window end");

  a_hund_range: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> (mean_hundredths <= HUND_W'(99)))
    else $error("hundredths out of range");

endmodule

[hdl/tmsa_controller.sv]
// sequencing of accumulate, trim, divide and report delivery
// depends on tmsa_pkg; commands tmsa_datapath
module tmsa_controller #(
  parameter int DIV_STEPS = 29
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  input  tmsa_pkg::tmsa_status_t  status,
  output tmsa_pkg::tmsa_cmd_t     cmd
);
  import tmsa_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_TRIM,
    ST_DIVIDE,
    ST_DELIVER
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] step_cnt;

  assign in_ready     = (state == ST_ACCUM);
  assign cmd.accept   = (state == ST_ACCUM) && in_valid;
  assign cmd.trim     = (state == ST_TRIM);
  assign cmd.div_step = (state == ST_DIVIDE);
  assign cmd.load_out = (state == ST_DELIVER) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACCUM;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_ACCUM: begin
          if (in_valid && status.window_last) begin
            state <= ST_TRIM;
          end
        end
        ST_TRIM: begin
          step_cnt <= '0;
          state    <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          step_cnt <= step_cnt + CNT_W'(1);
          if (step_cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= ST_DELIVER;
          end
        end
        ST_DELIVER: begin
          if (cmd.load_out) begin
            state <= ST_ACCUM;
          end
        end
        default: begin
          state <= ST_ACCUM;
        end
      endcase
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("report register overwritten while pending");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != ST_ACCUM) |-> !in_ready)
    else $error("sample taken while computing a report");

  a_divide_length: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TRIM) |=> ##(DIV_STEPS) (state == ST_DELIVER))
    else $error("divide did not run its full length");

endmodule

[hdl/trimmed_mean_sample_aggregator.sv]
// top level of the trimmed mean sample aggregator
// depends on tmsa_pkg, tmsa_controller and tmsa_datapath
//
// Takes one unsigned sample (8 fraction bits) per transfer and keeps a running
// sum, minimum and maximum over a window of N samples, N set by window_length
// (clamped to 5..MAX_WINDOW). The sample that closes a window triggers one
// report: the trimmed mean (sum - min - max) / (N - 2), truncated, split into a
// 16-bit integer part and hundredths, the sensor code (sensor_kind + 1), a
// wrapping 8-bit sequence number and an alarm when the mean is strictly above
// the fixed threshold of the selected sensor kind. Ordinary samples can be
// taken back to back. After the window-closing sample in_ready stays low while
// the block forms the trimmed sum, runs the serial restoring divider at one
// quotient bit per cycle for SUM_W bits (SUM_W = sample bits plus log2 of
// MAX_WINDOW rounded up) and loads the report register once any pending report
// has transferred. The report register decouples the output: a new window
// fills while a report waits, and only a second report waits for the first to
// transfer. Any config write restarts the window and keeps the sequence number;
// writes are expected only while the block is idle.
module trimmed_mean_sample_aggregator #(
  parameter int MAX_WINDOW  = 30,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  // config write port
  input  logic                              cfg_write,
  input  logic [tmsa_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tmsa_pkg::CFG_DATA_W-1:0]   cfg_data,
  // sample channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tmsa_pkg::SAMPLE_IN_W-1:0]  sample_value,
  // report channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tmsa_pkg::SEQ_W-1:0]        report_seq,
  output logic [tmsa_pkg::CODE_W-1:0]       sensor_code,
  output logic [tmsa_pkg::MEAN_INT_W-1:0]   mean_integer,
  output logic [tmsa_pkg::HUND_W-1:0]       mean_hundredths,
  output logic                              alarm
);
  import tmsa_pkg::*;

  // effective sample width and accumulator width
  localparam int IN_W  = (SAMPLE_BITS < SAMPLE_IN_W) ? SAMPLE_BITS : SAMPLE_IN_W;
  localparam int SUM_W = IN_W + $clog2(MAX_WINDOW);

  tmsa_cmd_t    cmd;
  tmsa_status_t status;

  // sequencer: accumulate, trim, divide, deliver
  tmsa_controller #(
    .DIV_STEPS (SUM_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // accumulators, divider and report register
  tmsa_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .sample_value    (sample_value),
    .cmd             (cmd),
    .status          (status),
    .report_seq      (report_seq),
    .sensor_code     (sensor_code),
    .mean_integer    (mean_integer),
    .mean_hundredths (mean_hundredths),
    .alarm           (alarm)
  );

endmodule
